// ===== design/cdt_discrete_gaussian_sampler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the discrete Gaussian sampler
// Shared concurrent assertion forms; each use names its own label and message.
// ---------------------------------------------------------------------------
`ifndef CDT_DISCRETE_GAUSSIAN_SAMPLER_ASSERT_SVH
`define CDT_DISCRETE_GAUSSIAN_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CDT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cdt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CDT sampler package
// Widths, codes and the token that walks along the cell chain.
// ---------------------------------------------------------------------------
package cdt_pkg;

   // Default and largest table depth
   localparam int CDT_TABLE_DEPTH = 64;
   localparam int CDT_MAX_DEPTH   = 256;

   // Field widths
   localparam int IDX_W      = 6;
   localparam int PROB_W     = 32;
   localparam int MOD_W      = 64;
   localparam int SAMPLE_W   = 8;
   localparam int LEN_W      = 7;
   localparam int HZW_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   // Magnitude must hold the largest depth itself
   localparam int MAG_W      = $clog2(CDT_MAX_DEPTH + 1);

   // Reset values of the control registers
   localparam logic [MOD_W-1:0] MODULUS_RESET      = 64'd1;
   localparam logic [HZW_W-1:0] HZW_RESET          = 32'd0;
   localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 7'd64;

   // Centre point of the uniform word
   localparam logic [PROB_W-1:0] CENTRE = 32'h8000_0000;

   typedef enum logic {
      CDT_OP_LOAD   = 1'b0,
      CDT_OP_SAMPLE = 1'b1
   } cdt_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CDT_CSR_MODULUS          = 2'd0,
      CDT_CSR_HALF_ZERO_WEIGHT = 2'd1,
      CDT_CSR_TABLE_LENGTH     = 2'd2
   } cdt_csr_type;

   // One item in flight along the chain
   typedef struct packed {
      logic              vld;
      logic              is_sample;
      logic [IDX_W-1:0]  entry_index;
      logic [PROB_W-1:0] operand;      // load value, or excess for a sample
      logic              positive;
      logic              zero;
      logic              found;
      logic [MAG_W-1:0]  mag;
   } cdt_token_type;

endpackage

// ===== design/cdt_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CDT request channel
// Valid/ready channel carrying table loads and sample draws.
// ---------------------------------------------------------------------------
interface cdt_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [5:0]  entry_index;
   logic [31:0] entry_value;
   logic [31:0] random_word;

   modport source (output valid, opcode, entry_index, entry_value, random_word,
                   input ready);
   modport sink   (input valid, opcode, entry_index, entry_value, random_word,
                   output ready);
endinterface

// ===== design/cdt_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CDT response channel
// Valid/ready channel carrying one drawn sample per transfer.
// ---------------------------------------------------------------------------
interface cdt_rsp_if;
   logic               valid;
   logic               ready;
   logic [63:0]        sample_mod;
   logic signed [7:0]  sample_signed;
   logic               search_missed;

   modport source (output valid, sample_mod, sample_signed, search_missed,
                   input ready);
   modport sink   (input valid, sample_mod, sample_signed, search_missed,
                   output ready);
endinterface

// ===== design/cdt_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CDT chain cell
// Holds one cumulative table entry; loads write it in passing, samples test
// it against their excess and record the first hit.
// ---------------------------------------------------------------------------
module cdt_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic [cdt_pkg::LEN_W-1:0]    table_length,
   input  cdt_pkg::cdt_token_type       tok_in,
   output cdt_pkg::cdt_token_type       tok_out
);
   import cdt_pkg::*;

   logic [PROB_W-1:0] entry_ff;
   cdt_token_type     token_ff;
   cdt_token_type     token_in;
   logic              active;
   logic              hit;
   logic              write_entry;

   // Cell takes part in the search only inside the programmed length
   assign active = (CELL_INDEX < int'(table_length));

   assign hit = tok_in.vld && tok_in.is_sample && !tok_in.zero && !tok_in.found
                && active && (entry_ff >= tok_in.operand);

   assign write_entry = enable && tok_in.vld && !tok_in.is_sample
                        && (int'(tok_in.entry_index) == CELL_INDEX);

   // Mark the first hit and record its magnitude
   always_comb begin
      token_in = tok_in;
      if (hit) begin
         token_in.found = 1'b1;
         token_in.mag   = MAG_W'(CELL_INDEX + 1);
      end
   end

   // Write the entry as a matching load passes
   always_ff @(posedge clock) begin
      if (write_entry) begin
         entry_ff <= tok_in.operand;
      end
   end

   // Advance the token to the neighbour
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.vld <= 1'b0;
      end else if (enable) begin
         token_ff <= token_in;
      end
   end

   assign tok_out = token_ff;

endmodule

// ===== design/cdt_discrete_gaussian_sampler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CDT discrete Gaussian sampler
// Table-inversion sampler built as a chain of TABLE_DEPTH entry cells.
// ---------------------------------------------------------------------------
// Takes one request per cycle unless the chain stalls, and passes each
// sample along the cell chain: a head stage centres the word and forms the
// excess, each cell holds one table entry and tests it as the item passes,
// and an output register forms the ring value.
// Loads travel the same chain and write their cell on the way, so a sample
// always sees every load sent before it. Loads give no response. The chain
// stalls only when a finished sample waits at the output; empty slots still
// drain past a waiting response. Configure only while the chain is empty.
// Table entries are undefined until loaded; no reset sweep is needed.
`include "cdt_discrete_gaussian_sampler_assert.svh"

module cdt_discrete_gaussian_sampler #(
   parameter int TABLE_DEPTH = cdt_pkg::CDT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   cdt_req_if.sink                          req_bus,
   cdt_rsp_if.source                        rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [cdt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cdt_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import cdt_pkg::*;

   localparam logic [MAG_W-1:0] DEPTH_K = MAG_W'(TABLE_DEPTH);

   // Control registers
   logic [MOD_W-1:0]  modulus_ff;
   logic [HZW_W-1:0]  half_zero_weight_ff;
   logic [LEN_W-1:0]  table_length_ff;

   // Chain
   cdt_token_type     chain [0:TABLE_DEPTH];
   cdt_token_type     head_ff;
   cdt_token_type     head_in;
   cdt_token_type     tail;
   logic              adv;
   logic              tail_sample;
   logic              take;

   // Head arithmetic
   logic [PROB_W-1:0] mag;
   logic              positive;

   // Output stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [MOD_W-1:0]       sample_mod_ff;
   logic [MOD_W-1:0]       sample_mod_in;
   logic [SAMPLE_W-1:0]    sample_signed_ff;
   logic [SAMPLE_W-1:0]    sample_signed_in;
   logic                   search_missed_ff;
   logic                   search_missed_in;
   logic [MAG_W-1:0]       len_eff;
   logic [MAG_W-1:0]       k;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff          <= MODULUS_RESET;
         half_zero_weight_ff <= HZW_RESET;
         table_length_ff     <= TABLE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CDT_CSR_MODULUS:          modulus_ff          <= csr_write_data;
            CDT_CSR_HALF_ZERO_WEIGHT: half_zero_weight_ff <= csr_write_data[HZW_W-1:0];
            CDT_CSR_TABLE_LENGTH:     table_length_ff     <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance unless a sample at the tail waits on a full output register
   assign tail        = chain[TABLE_DEPTH];
   assign tail_sample = tail.vld && tail.is_sample;
   assign take        = rsp_valid_ff && rsp_bus.ready;
   assign adv         = !tail_sample || !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // Centre the word and form the excess over half the zero weight
   always_comb begin
      if (req_bus.random_word >= CENTRE) begin
         positive = (req_bus.random_word != CENTRE);
         mag      = req_bus.random_word - CENTRE;
      end else begin
         positive = 1'b0;
         mag      = CENTRE - req_bus.random_word;
      end
      head_in.vld         = req_bus.valid;
      head_in.is_sample   = (req_bus.opcode == CDT_OP_SAMPLE);
      head_in.entry_index = req_bus.entry_index;
      head_in.positive    = positive;
      head_in.zero        = (mag <= half_zero_weight_ff);
      head_in.found       = 1'b0;
      head_in.mag         = '0;
      if (req_bus.opcode == CDT_OP_SAMPLE) begin
         head_in.operand = mag - half_zero_weight_ff;
      end else begin
         head_in.operand = req_bus.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.vld <= 1'b0;
      end else if (adv) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   // Row of entry cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      cdt_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (adv),
         .table_length (table_length_ff),
         .tok_in       (chain[g]),
         .tok_out      (chain[g+1])
      );
   end

   // Resolve magnitude: zero, first hit, or saturated length on a miss
   always_comb begin
      if (MAG_W'(table_length_ff) > DEPTH_K) begin
         len_eff = DEPTH_K;
      end else begin
         len_eff = MAG_W'(table_length_ff);
      end
      priority if (tail.zero) begin
         k                = '0;
         search_missed_in = 1'b0;
      end else if (tail.found) begin
         k                = tail.mag;
         search_missed_in = 1'b0;
      end else begin
         k                = len_eff;
         search_missed_in = 1'b1;
      end
      priority if (k == '0) begin
         sample_mod_in    = '0;
         sample_signed_in = '0;
      end else if (tail.positive) begin
         sample_mod_in    = MOD_W'(k);
         sample_signed_in = k[SAMPLE_W-1:0];
      end else begin
         sample_mod_in    = modulus_ff - MOD_W'(k);
         sample_signed_in = SAMPLE_W'(0) - k[SAMPLE_W-1:0];
      end
   end

   // Output register: load a finished sample, drop on transfer
   always_comb begin
      priority if (tail_sample && adv) begin
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_sample && adv) begin
         sample_mod_ff    <= sample_mod_in;
         sample_signed_ff <= sample_signed_in;
         search_missed_ff <= search_missed_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.sample_mod    = sample_mod_ff;
   assign rsp_bus.sample_signed = sample_signed_ff;
   assign rsp_bus.search_missed = search_missed_ff;

   // A zero sample is zero in the ring too
   `CDT_ASSERT_IMPLY(a_zero_sample_mod, clock, reset, rsp_valid_ff && (sample_signed_ff == '0), sample_mod_ff == '0, "zero sample with nonzero ring value")

   // A positive sample appears unchanged in the ring
   `CDT_ASSERT_IMPLY(a_positive_sample_mod, clock, reset, rsp_valid_ff && !sample_signed_ff[SAMPLE_W-1] && (sample_signed_ff != '0), sample_mod_ff == MOD_W'(sample_signed_ff), "positive sample ring value mismatch")

   // The chain stalls only behind a waiting sample
   `CDT_ASSERT_IMPLY(a_stall_cause, clock, reset, !adv, tail_sample && rsp_valid_ff && !rsp_bus.ready, "chain stalled without a waiting sample")

   // A held response keeps its ring value and miss flag while it waits
   `CDT_ASSERT_NEXT(a_hold_payload, clock, reset, rsp_valid_ff && !rsp_bus.ready, $stable(sample_mod_ff) && $stable(search_missed_ff), "waiting response changed")

endmodule
